[rtl/insertable_vector_store_macros.svh]
// ----------------------------------------------------------------------------
// Insertable vector store assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INSERTABLE_VECTOR_STORE_MACROS_SVH
`define INSERTABLE_VECTOR_STORE_MACROS_SVH

// Same-cycle implication.
`define IVS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IVS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ivs_pkg.sv]
// ----------------------------------------------------------------------------
// Insertable vector store package
// Field widths, operation and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ivs_pkg;

   // Payload field widths.
   localparam int OP_W     = 3;
   localparam int INDEX_W  = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP    = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_GET    = 3'd4;
   localparam logic [OP_W-1:0] OP_DUMP   = 3'd5;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;   // Execute the request accepted in this cycle.
      logic step;   // Load the next element of a running dump.
   } ivs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic more;   // The result being loaded is not the final one.
   } ivs_sts_type;

endpackage

`default_nettype wire

[rtl/ivs_ctrl.sv]
// ----------------------------------------------------------------------------
// Insertable vector store controller
// Tracks whether a single result or a dump stream is pending and issues the
// execute and step commands to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ivs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output ivs_pkg::ivs_cmd_type      cmd,
   input  wire ivs_pkg::ivs_sts_type sts
);
   import ivs_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SINGLE,
      S_STREAM
   } state_type;

   state_type state_ff;
   state_type state_in;

   // A new request may enter when nothing is pending or the pending final
   // result leaves in this cycle.
   always_comb begin
      req_ready = (state_ff == S_IDLE) || ((state_ff == S_SINGLE) && rsp_ready);
      rsp_valid = (state_ff != S_IDLE);
      cmd.exec  = req_valid && req_ready;
      cmd.step  = (state_ff == S_STREAM) && rsp_ready;
   end

   // Next state selection.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.exec) begin
               state_in = sts.more ? S_STREAM : S_SINGLE;
            end
         end
         S_SINGLE: begin
            if (cmd.exec) begin
               state_in = sts.more ? S_STREAM : S_SINGLE;
            end else if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         S_STREAM: begin
            if (cmd.step) begin
               state_in = sts.more ? S_STREAM : S_SINGLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ivs_dpath.sv]
// ----------------------------------------------------------------------------
// Insertable vector store datapath
// Row of storage cells that shift up in parallel on insert, element count,
// dump pointer, one read mux and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ivs_dpath #(
   parameter int CAPACITY = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ivs_pkg::ivs_cmd_type                cmd,
   output ivs_pkg::ivs_sts_type                     sts,
   input  wire logic [ivs_pkg::OP_W-1:0]            req_op,
   input  wire logic [ivs_pkg::INDEX_W-1:0]         req_index,
   input  wire logic signed [ivs_pkg::DATA_W-1:0]   req_value,
   output logic [ivs_pkg::STATUS_W-1:0]             rsp_status,
   output logic signed [ivs_pkg::DATA_W-1:0]        rsp_data,
   output logic [ivs_pkg::COUNT_W-1:0]              rsp_count,
   output logic                                     rsp_last,
   output logic                                     rsp_empty_res
);
   import ivs_pkg::*;

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (FW > INDEX_W) ? FW : INDEX_W;

   logic signed [DATA_W-1:0] cell_ff [CAPACITY];
   logic [FW-1:0]            fill_ff;
   logic [FW-1:0]            fill_in;
   logic [FW-1:0]            ptr_ff;
   logic [FW-1:0]            ptr_in;
   logic [FW-1:0]            ptr_nxt;
   logic [CMP_W-1:0]         idx_ext;
   logic [CMP_W-1:0]         fill_ext;
   logic [CMP_W-1:0]         wr_pos;
   logic                     wr_ok;
   logic                     full;
   logic [AW-1:0]            rd_addr;
   logic signed [DATA_W-1:0] rd_data;
   logic                     load;
   logic [STATUS_W-1:0]      status_in;
   logic signed [DATA_W-1:0] data_in;
   logic                     empty_in;

   assign idx_ext  = CMP_W'(req_index);
   assign fill_ext = CMP_W'(fill_ff);
   assign full     = (fill_ff == FW'(CAPACITY));
   assign ptr_nxt  = ptr_ff + FW'(1);

   // Single read port: dump pointer while streaming, slot zero for the
   // first dump element, otherwise the requested index.
   always_comb begin
      if (cmd.step) begin
         rd_addr = ptr_ff[AW-1:0];
      end else if (req_op == OP_DUMP) begin
         rd_addr = '0;
      end else begin
         rd_addr = AW'(req_index);
      end
   end

   assign rd_data = cell_ff[rd_addr];

   // Operation decode and next values of count, pointer and result.
   always_comb begin
      wr_ok     = 1'b0;
      wr_pos    = fill_ext;
      fill_in   = fill_ff;
      ptr_in    = ptr_ff;
      load      = 1'b0;
      status_in = ST_OK;
      data_in   = '0;
      empty_in  = 1'b0;
      sts.more  = 1'b0;
      if (cmd.exec) begin
         load = 1'b1;
         unique case (req_op)
            OP_PUSH: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_ok   = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end
            end
            OP_INSERT: begin
               if (idx_ext > fill_ext) begin
                  status_in = ST_RANGE;
               end else if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_ok   = 1'b1;
                  wr_pos  = idx_ext;
                  fill_in = fill_ff + FW'(1);
               end
            end
            OP_POP: begin
               if (fill_ff != '0) begin
                  fill_in = fill_ff - FW'(1);
               end
            end
            OP_CLEAR: begin
               fill_in = '0;
            end
            OP_GET: begin
               if (idx_ext >= fill_ext) begin
                  status_in = ST_RANGE;
               end else begin
                  data_in = rd_data;
               end
            end
            OP_DUMP: begin
               if (fill_ff == '0) begin
                  empty_in = 1'b1;
               end else begin
                  data_in  = rd_data;
                  ptr_in   = FW'(1);
                  sts.more = (fill_ff > FW'(1));
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end else if (cmd.step) begin
         load     = 1'b1;
         data_in  = rd_data;
         ptr_in   = ptr_nxt;
         sts.more = (ptr_nxt < fill_ff);
      end
   end

   // Storage cells: the written slot takes the new word and every slot above
   // it takes its lower neighbor, so an insert shifts the row in parallel.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_base
         always_ff @(posedge clock) begin
            if (wr_ok && (wr_pos == CMP_W'(i))) begin
               cell_ff[i] <= req_value;
            end
         end
      end else begin : g_upper
         always_ff @(posedge clock) begin
            if (wr_ok) begin
               if (wr_pos == CMP_W'(i)) begin
                  cell_ff[i] <= req_value;
               end else if (wr_pos < CMP_W'(i)) begin
                  cell_ff[i] <= cell_ff[i-1];
               end
            end
         end
      end
   end

   // Element count and dump pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ptr_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         ptr_ff  <= ptr_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status    <= status_in;
         rsp_data      <= data_in;
         rsp_count     <= COUNT_W'(fill_in);
         rsp_last      <= !sts.more;
         rsp_empty_res <= empty_in;
      end
   end

endmodule

`default_nettype wire

[rtl/insertable_vector_store.sv]
// A result is presented in the cycle after its request is accepted.
// Push, insert, pop, clear and get are accepted one per cycle when the result
// side keeps up; a dump of n elements streams n results, one per cycle while
// rsp_ready is high, and holds off new requests until its final result is taken.
// Reset clears the element count and control; the storage cells are not
// cleared and no clearing pass runs, so requests are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "insertable_vector_store_macros.svh"

// ----------------------------------------------------------------------------
// Insertable vector store
// Bounded ordered store of signed words with push, insert, pop, clear, get
// and dump, built as a controller and a shifting-cell datapath.
// ----------------------------------------------------------------------------
module insertable_vector_store #(
   parameter int CAPACITY = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [ivs_pkg::OP_W-1:0]           req_op,
   input  wire logic [ivs_pkg::INDEX_W-1:0]        req_index,
   input  wire logic signed [ivs_pkg::DATA_W-1:0]  req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [ivs_pkg::STATUS_W-1:0]            rsp_status,
   output logic signed [ivs_pkg::DATA_W-1:0]       rsp_data,
   output logic [ivs_pkg::COUNT_W-1:0]             rsp_count,
   output logic                                    rsp_last,
   output logic                                    rsp_empty_res
);
   import ivs_pkg::*;

   ivs_cmd_type cmd;
   ivs_sts_type sts;

   // Sequencing of requests and results.
   ivs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Storage, count and result register.
   ivs_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_op        (req_op),
      .req_index     (req_index),
      .req_value     (req_value),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_count     (rsp_count),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res)
   );

   // A request transfer never overwrites a result that is still waiting.
   `IVS_ASSERT_NOW(a_no_overwrite, req_valid && req_ready,
      !rsp_valid || rsp_ready, "result overwritten")

   // An empty dump result is final and reports a zero count.
   `IVS_ASSERT_NOW(a_empty_final, rsp_valid && rsp_empty_res,
      rsp_last && (rsp_count == '0), "bad empty dump result")

   // A non-final dump result is followed by another result.
   `IVS_ASSERT_NEXT(a_stream_cont, rsp_valid && rsp_ready && !rsp_last,
      rsp_valid, "dump stream broken")

   // The reported count never exceeds the capacity.
   `IVS_ASSERT_NOW(a_count_cap, rsp_valid, rsp_count <= CAPACITY, "count above capacity")

endmodule

`default_nettype wire
